>>> hw/rtl/zrt_pkg.sv
// Shared types, constants and widths for the zero-range torus step unit.
package zrt_pkg;

  localparam int SIDE_DEFAULT = 32;
  localparam int DVD_W = 24;
  localparam int DVS_W = 17;
  localparam int RATE_W = 25;
  localparam int SUM_W = 40;
  localparam int PART_W = 42;
  localparam int OCC_W = 16;
  localparam int SITE_W = 10;
  localparam int PADDR_W = 3;

  localparam logic [RATE_W-1:0] RATE_ONE = RATE_W'(65536);

  localparam logic [PADDR_W-1:0] ADDR_PARTICLE_COUNT = 3'h0;
  localparam logic [PADDR_W-1:0] ADDR_RATE_BIAS = 3'h4;

  typedef enum logic [1:0] {
    OP_INIT = 2'd0,
    OP_STEP = 2'd1,
    OP_READ = 2'd2,
    OP_NOP = 2'd3
  } opcode_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_INIT_Q,
    S_INIT_G0,
    S_INIT_G1,
    S_INIT_FILL,
    S_REF_RD,
    S_REF_START,
    S_REF_WAIT,
    S_MUL_LO,
    S_MUL_HI,
    S_WALK,
    S_SRC_RD,
    S_SRC_DATA,
    S_DST_DATA,
    S_DIV_SRC,
    S_DIV_DST,
    S_WR_SRC,
    S_WR_DST,
    S_READ_RD,
    S_EMIT
  } state_t;

endpackage

>>> hw/rtl/zrt_div.sv
// Restoring divider, one quotient bit per cycle.
module zrt_div import zrt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DVD_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem;
  logic [DVD_W-1:0] quo;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             fits;

  assign shifted = {rem, quo[DVD_W-1]};
  assign diff = shifted - {1'b0, dvs};
  assign fits = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
      cnt <= CNT_W'(DVD_W);
    end else if (busy) begin
      rem <= fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      quo <= {quo[DVD_W-2:0], fits};
      cnt <= cnt - CNT_W'(1);
    end
  end

  assign quotient = quo;
  assign remainder = rem;

endmodule

>>> hw/rtl/zero_range_torus_monte_carlo_step_unit.sv
// Top level: zero-range particle process on a torus, memory-based step sequencer.
//
//  channel   signals                                   direction
//  -------   ---------------------------------------   ---------
//  config    psel penable pwrite paddr pwdata prdata   APB slave, pready tied high
//  input     in_valid in_ready opcode dice dir site    one command per transfer
//  output    out_valid out_ready status ... new_peak   one result per command
//
// Sequencing: one command at a time. An init splits particle_count by a
// reciprocal multiply, runs up to two divisions and then writes one site per
// cycle. A step scans the rate memory one site per cycle (up to SIDE*SIDE sites)
// and runs up to two divisions; the first step after a rate_bias write first
// rebuilds the rate memory, one division per occupied site.
// Reset clears control state only; the site memories are masked as empty until
// the first init. A stalled result holds in the output register.
module zero_range_torus_monte_carlo_step_unit import zrt_pkg::*; #(
  parameter int SIDE = SIDE_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic [15:0]        dice,
  input  logic [1:0]         direction,
  input  logic [SITE_W-1:0]  read_site,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               status,
  output logic [SITE_W-1:0]  source_site,
  output logic [SITE_W-1:0]  dest_site,
  output logic [OCC_W-1:0]   occupancy,
  output logic [OCC_W-1:0]   peak,
  output logic               new_peak
);

  localparam int NSITES = SIDE * SIDE;
  localparam int AW = $clog2(NSITES);
  localparam int RW = $clog2(SIDE);
  localparam logic [AW-1:0] LAST = AW'(NSITES - 1);
  localparam logic [RW-1:0] RMAX = RW'(SIDE - 1);
  localparam logic [DVS_W-1:0] NSITES_D = DVS_W'(NSITES);
  // reciprocal of the site count, exact for every 16-bit particle count
  localparam int RK = OCC_W + AW;
  localparam logic [OCC_W:0] RECIP =
    (OCC_W+1)'(((64'd1 << RK) + 64'(NSITES) - 64'd1) / 64'(NSITES));

  state_t state, state_next;

  // configuration and global state
  logic [OCC_W-1:0] particle_count;
  logic [OCC_W-1:0] rate_bias;
  logic [SUM_W-1:0] weight_sum;
  logic             filled;
  logic             stale;

  // latched command
  logic [15:0] dice_r;
  logic [1:0]  dir_r;

  // divider
  logic             div_start;
  logic [DVD_W-1:0] div_a;
  logic [DVS_W-1:0] div_d;
  logic             div_busy;
  logic             div_done;
  logic [DVD_W-1:0] div_q;
  logic [DVS_W-1:0] div_r;
  logic [DVD_W-1:0] bias_dvd;

  // init
  logic [OCC_W-1:0]  qv;
  logic [DVS_W-1:0]  remv;
  logic [RATE_W-1:0] g0, g1;
  logic [SUM_W-1:0]  fill_sum, fill_sum_next;
  logic              fill_extra;
  logic [OCC_W-1:0]  fill_v;
  logic [RATE_W-1:0] fill_rate;
  logic [2*OCC_W:0]  init_prod;
  logic [OCC_W-1:0]  init_q;
  logic [OCC_W-1:0]  init_rem;

  // walk
  logic [AW-1:0]     idx, idx_d;
  logic [RW-1:0]     row, col, row_d, col_d;
  logic              walk_vld, issue_done;
  logic [PART_W-1:0] partial, run_sum;
  logic              hit;
  logic [SUM_W-1:0]  target;
  logic [35:0]       prod_lo, prod_hi;
  logic [55:0]       prod_full;

  // move
  logic [AW-1:0]     src, dst, dst_idx;
  logic [RW-1:0]     src_row, src_col, dst_row, dst_col;
  logic [OCC_W-1:0]  so, speak, dn, dpeak, so_m1, dn1;
  logic [DVS_W-1:0]  dn_p1;
  logic [RATE_W-1:0] gso, gdn, gsm, gdp;
  logic              np;
  logic [SUM_W-1:0]  ws_upd;

  // result
  logic              res_status, res_np;
  logic [SITE_W-1:0] res_src, res_dst;
  logic [OCC_W-1:0]  res_occ, res_peak;

  // memories
  logic [2*OCC_W-1:0] occ_mem [NSITES];
  logic [RATE_W-1:0]  rate_mem [NSITES];
  logic [2*OCC_W-1:0] occ_q;
  logic [RATE_W-1:0]  rate_q;
  logic [AW-1:0]      occ_ra, rate_ra, mem_wa;
  logic               occ_we, rate_we;
  logic [2*OCC_W-1:0] occ_wd;
  logic [RATE_W-1:0]  rate_wd;
  logic               ref_write;
  logic               emit_go;
  logic               cfg_wr;

  zrt_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_d),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr)
      ADDR_PARTICLE_COUNT: prdata = {16'h0, particle_count};
      ADDR_RATE_BIAS:      prdata = {16'h0, rate_bias};
      default:             prdata = '0;
    endcase
  end

  // ---------------- datapath helpers ----------------
  assign bias_dvd = {rate_bias, 8'h00};
  assign in_ready = (state == S_IDLE);
  assign emit_go = (state == S_EMIT) && (!out_valid || out_ready);

  // split the particle count: quotient by reciprocal, remainder from the held quotient
  assign init_prod = (2*OCC_W+1)'(particle_count) * (2*OCC_W+1)'(RECIP);
  assign init_q = OCC_W'(init_prod >> RK);
  assign init_rem = particle_count - OCC_W'(32'(qv) * 32'(NSITES));

  assign fill_extra = DVS_W'(idx) < remv;
  assign fill_v = qv + OCC_W'(fill_extra);
  assign fill_rate = fill_extra ? g1 : g0;
  assign fill_sum_next = fill_sum + SUM_W'(fill_rate);

  assign prod_hi = dice_r * weight_sum[39:20];
  assign prod_full = 56'(prod_lo) + (56'(prod_hi) << 20);

  assign run_sum = partial + PART_W'(rate_q);
  assign hit = PART_W'(target) < run_sum;

  assign so_m1 = so - OCC_W'(1);
  assign dn1 = dn + OCC_W'(1);
  assign dn_p1 = DVS_W'(dn) + DVS_W'(1);
  assign np = dn1 > dpeak;
  assign ws_upd = weight_sum + SUM_W'(gsm) + SUM_W'(gdp) - SUM_W'(gso) - SUM_W'(gdn);

  // torus neighbour of the jumping site
  always_comb begin
    dst_row = src_row;
    dst_col = src_col;
    case (dir_r)
      2'd0:    dst_row = (src_row == '0) ? RMAX : src_row - RW'(1);
      2'd1:    dst_row = (src_row == RMAX) ? '0 : src_row + RW'(1);
      2'd2:    dst_col = (src_col == '0) ? RMAX : src_col - RW'(1);
      default: dst_col = (src_col == RMAX) ? '0 : src_col + RW'(1);
    endcase
    dst_idx = AW'(int'(dst_row) * SIDE + int'(dst_col));
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start = 1'b0;
    div_a = bias_dvd;
    div_d = '0;
    occ_ra = idx;
    rate_ra = idx;
    mem_wa = idx;
    occ_we = 1'b0;
    rate_we = 1'b0;
    occ_wd = {fill_v, fill_v};
    rate_wd = fill_rate;
    ref_write = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (opcode)
            OP_INIT: begin
              state_next = S_INIT_Q;
            end
            OP_STEP: begin
              if (weight_sum == '0) state_next = S_EMIT;
              else if (stale) state_next = S_REF_RD;
              else state_next = S_MUL_LO;
            end
            OP_READ: begin
              occ_ra = AW'(read_site);
              if (filled && DVS_W'(read_site) < NSITES_D) state_next = S_READ_RD;
              else state_next = S_EMIT;
            end
            default: state_next = S_EMIT;
          endcase
        end
      end
      S_INIT_Q: begin
        if (init_q != '0) begin
          div_start = 1'b1;
          div_d = DVS_W'(init_q);
        end
        state_next = S_INIT_G0;
      end
      S_INIT_G0: begin
        if (qv == '0 || div_done) begin
          div_start = 1'b1;
          div_d = DVS_W'(qv) + DVS_W'(1);
          state_next = S_INIT_G1;
        end
      end
      S_INIT_G1: begin
        if (div_done) state_next = S_INIT_FILL;
      end
      S_INIT_FILL: begin
        occ_we = 1'b1;
        rate_we = 1'b1;
        if (idx == LAST) state_next = S_EMIT;
      end
      S_REF_RD: begin
        state_next = S_REF_START;
      end
      S_REF_START: begin
        if (occ_q[OCC_W-1:0] == '0) begin
          rate_we = 1'b1;
          rate_wd = '0;
          ref_write = 1'b1;
          state_next = (idx == LAST) ? S_MUL_LO : S_REF_RD;
        end else begin
          div_start = 1'b1;
          div_d = DVS_W'(occ_q[OCC_W-1:0]);
          state_next = S_REF_WAIT;
        end
      end
      S_REF_WAIT: begin
        if (div_done) begin
          rate_we = 1'b1;
          rate_wd = RATE_ONE + RATE_W'(div_q);
          ref_write = 1'b1;
          state_next = (idx == LAST) ? S_MUL_LO : S_REF_RD;
        end
      end
      S_MUL_LO: state_next = S_MUL_HI;
      S_MUL_HI: state_next = S_WALK;
      S_WALK: begin
        if (walk_vld) begin
          if (hit) state_next = S_SRC_RD;
          else if (idx_d == LAST) state_next = S_EMIT;
        end
      end
      S_SRC_RD: begin
        occ_ra = src;
        rate_ra = src;
        state_next = S_SRC_DATA;
      end
      S_SRC_DATA: begin
        occ_ra = dst;
        rate_ra = dst;
        state_next = S_DST_DATA;
      end
      S_DST_DATA: begin
        if (so_m1 != '0) begin
          div_start = 1'b1;
          div_d = DVS_W'(so_m1);
        end
        state_next = S_DIV_SRC;
      end
      S_DIV_SRC: begin
        if (so_m1 == '0 || div_done) begin
          div_start = 1'b1;
          div_d = dn_p1;
          state_next = S_DIV_DST;
        end
      end
      S_DIV_DST: begin
        if (div_done) state_next = S_WR_SRC;
      end
      S_WR_SRC: begin
        occ_we = 1'b1;
        rate_we = 1'b1;
        mem_wa = src;
        occ_wd = {speak, so_m1};
        rate_wd = gsm;
        state_next = S_WR_DST;
      end
      S_WR_DST: begin
        occ_we = 1'b1;
        rate_we = 1'b1;
        mem_wa = dst;
        occ_wd = {(np ? dn1 : dpeak), dn1};
        rate_wd = gdp;
        state_next = S_EMIT;
      end
      S_READ_RD: state_next = S_EMIT;
      S_EMIT: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      particle_count <= '0;
      rate_bias <= OCC_W'(256);
      weight_sum <= '0;
      filled <= 1'b0;
      stale <= 1'b0;
      out_valid <= 1'b0;
      walk_vld <= 1'b0;
      issue_done <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr)
          ADDR_PARTICLE_COUNT: particle_count <= pwdata[OCC_W-1:0];
          ADDR_RATE_BIAS: begin
            rate_bias <= pwdata[OCC_W-1:0];
            stale <= 1'b1;
          end
          default: ;
        endcase
      end
      // load the next result, or drop a taken one
      if (emit_go) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      if (state == S_INIT_FILL && idx == LAST) begin
        weight_sum <= fill_sum_next;
        filled <= 1'b1;
        stale <= 1'b0;
      end
      if (ref_write && idx == LAST) stale <= 1'b0;
      if (state == S_WR_DST) weight_sum <= ws_upd;
      if (state == S_MUL_HI) begin
        walk_vld <= 1'b0;
        issue_done <= 1'b0;
      end else if (state == S_WALK) begin
        walk_vld <= !issue_done;
        if (!issue_done && idx == LAST) issue_done <= 1'b1;
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      dice_r <= dice;
      dir_r <= direction;
      idx <= '0;
      res_status <= (opcode == OP_STEP) && (weight_sum == '0);
      res_src <= '0;
      res_dst <= (opcode == OP_READ) ? read_site : '0;
      res_occ <= '0;
      res_peak <= '0;
      res_np <= 1'b0;
    end
    if (state == S_INIT_Q) qv <= init_q;
    if (state == S_INIT_G0) remv <= DVS_W'(init_rem);
    if (state == S_INIT_G0 && (qv == '0 || div_done)) begin
      g0 <= (qv == '0) ? '0 : RATE_ONE + RATE_W'(div_q);
    end
    if (state == S_INIT_G1 && div_done) begin
      g1 <= RATE_ONE + RATE_W'(div_q);
      idx <= '0;
      fill_sum <= '0;
    end
    if (state == S_INIT_FILL) begin
      idx <= idx + AW'(1);
      fill_sum <= fill_sum_next;
    end
    if (ref_write) idx <= idx + AW'(1);
    if (state == S_MUL_LO) prod_lo <= dice_r * weight_sum[19:0];
    if (state == S_MUL_HI) begin
      target <= prod_full[55:16];
      idx <= '0;
      row <= '0;
      col <= '0;
      partial <= '0;
    end
    if (state == S_WALK) begin
      // advance the scan address in row-major order
      if (!issue_done) begin
        idx_d <= idx;
        row_d <= row;
        col_d <= col;
        if (idx != LAST) idx <= idx + AW'(1);
        if (col == RMAX) begin
          col <= '0;
          row <= row + RW'(1);
        end else begin
          col <= col + RW'(1);
        end
      end
      if (walk_vld) begin
        partial <= run_sum;
        if (hit) begin
          src <= idx_d;
          src_row <= row_d;
          src_col <= col_d;
        end else if (idx_d == LAST) begin
          res_status <= 1'b1;
        end
      end
    end
    if (state == S_SRC_RD) dst <= dst_idx;
    if (state == S_SRC_DATA) begin
      so <= occ_q[OCC_W-1:0];
      speak <= occ_q[2*OCC_W-1:OCC_W];
      gso <= rate_q;
    end
    if (state == S_DST_DATA) begin
      dn <= occ_q[OCC_W-1:0];
      dpeak <= occ_q[2*OCC_W-1:OCC_W];
      gdn <= rate_q;
    end
    if (state == S_DIV_SRC && (so_m1 == '0 || div_done)) begin
      gsm <= (so_m1 == '0) ? '0 : RATE_ONE + RATE_W'(div_q);
    end
    if (state == S_DIV_DST && div_done) gdp <= RATE_ONE + RATE_W'(div_q);
    if (state == S_WR_DST) begin
      res_src <= SITE_W'(src);
      res_dst <= SITE_W'(dst);
      res_occ <= dn1;
      res_peak <= np ? dn1 : dpeak;
      res_np <= np;
    end
    if (state == S_READ_RD) begin
      res_occ <= occ_q[OCC_W-1:0];
      res_peak <= occ_q[2*OCC_W-1:OCC_W];
    end
    if (emit_go) begin
      status <= res_status;
      source_site <= res_src;
      dest_site <= res_dst;
      occupancy <= res_occ;
      peak <= res_peak;
      new_peak <= res_np;
    end
  end

  // ---------------- site memories ----------------
  always_ff @(posedge clk) begin
    if (occ_we) occ_mem[mem_wa] <= occ_wd;
    occ_q <= occ_mem[occ_ra];
  end

  always_ff @(posedge clk) begin
    if (rate_we) rate_mem[mem_wa] <= rate_wd;
    rate_q <= rate_mem[rate_ra];
  end

endmodule

>>> hw/rtl/zrt_checker.sv
// Port-level checks for the zero-range torus step unit, bound to the top level.
module zrt_checker import zrt_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              status,
  input logic [SITE_W-1:0] source_site,
  input logic [SITE_W-1:0] dest_site,
  input logic [OCC_W-1:0]  occupancy,
  input logic [OCC_W-1:0]  peak,
  input logic              new_peak
);

  // one command in flight: a transfer closes the input side
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a command is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(occupancy) && $stable(status))
    else $error("stalled result changed");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> source_site == '0 && dest_site == '0 &&
      occupancy == '0 && peak == '0 && !new_peak)
    else $error("refused step carries data");

  a_new_peak: assert property (@(posedge clk) disable iff (rst)
    out_valid && new_peak |-> !status && occupancy == peak)
    else $error("new peak does not match occupancy");

endmodule

bind zero_range_torus_monte_carlo_step_unit zrt_checker u_zrt_checker (.*);

>>> dv/tb_zero_range_torus_monte_carlo_step_unit.sv
// Testbench for the zero-range torus step unit: predicted results checked per transfer.
`timescale 1ns / 1ps

module tb_zero_range_torus_monte_carlo_step_unit import zrt_pkg::*; ();

  localparam int NSITES = 1024;
  localparam int GRID = 32;
  localparam logic [39:0] SUM_MASK = 40'hFF_FFFF_FFFF;

  typedef struct {
    opcode_t     op;
    logic [15:0] dice;
    logic [1:0]  dir;
    logic [9:0]  site;
  } cmd_t;

  typedef struct {
    logic        status;
    logic [9:0]  src;
    logic [9:0]  dst;
    logic [15:0] occ;
    logic [15:0] pk;
    logic        raised;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] opcode = '0;
  logic [15:0] dice = '0;
  logic [1:0] direction = '0;
  logic [9:0] read_site = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic status;
  logic [9:0] source_site, dest_site;
  logic [15:0] occupancy, peak;
  logic new_peak;

  zero_range_torus_monte_carlo_step_unit u_top (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .dice(dice),
    .direction(direction), .read_site(read_site), .out_valid(out_valid),
    .out_ready(out_ready), .status(status), .source_site(source_site),
    .dest_site(dest_site), .occupancy(occupancy), .peak(peak), .new_peak(new_peak)
  );

  always #10 clk = ~clk;

  // Commands waiting for the driver, and results the grid model says must come back.
  cmd_t    pending_cmds[$];
  result_t expected_results[$];
  cmd_t    cur_cmd;
  int      n_driven = 0;
  int      n_accepted = 0;
  int      errors = 0;

  // Shadow copy of the grid and its configuration.
  logic [15:0] grid_occ[NSITES];
  logic [15:0] grid_peak[NSITES];
  logic [39:0] grid_sum;
  logic [15:0] cfg_count;
  logic [15:0] cfg_bias;

  function automatic logic [39:0] jump_rate(input logic [15:0] x);
    if (x == 16'd0) return 40'd0;
    return 40'd65536 + 40'((32'(cfg_bias) * 32'd256) / 32'(x));
  endfunction

  function automatic int torus_neighbor(input int s, input logic [1:0] d);
    int r;
    int c;
    r = s / GRID;
    c = s % GRID;
    case (d)
      2'd0: r = (r == 0) ? GRID - 1 : r - 1;
      2'd1: r = (r + 1) % GRID;
      2'd2: c = (c == 0) ? GRID - 1 : c - 1;
      default: c = (c + 1) % GRID;
    endcase
    return r * GRID + c;
  endfunction

  // Apply one command to the shadow grid and queue the result it must produce.
  task automatic predict_grid(input cmd_t c);
    result_t res;
    logic [63:0] target;
    logic [63:0] partial;
    logic [63:0] acc;
    logic [15:0] so, dn;
    int src, dst, q, rem;
    bit found;
    res = '{default: '0};
    case (c.op)
      OP_INIT: begin
        q = cfg_count / NSITES;
        rem = cfg_count % NSITES;
        acc = 0;
        for (int i = 0; i < NSITES; i++) begin
          grid_occ[i] = 16'(q + (i < rem ? 1 : 0));
          grid_peak[i] = grid_occ[i];
          acc += 64'(jump_rate(grid_occ[i]));
        end
        grid_sum = acc[39:0];
      end
      OP_STEP: begin
        found = 1'b0;
        src = 0;
        if (grid_sum != 40'd0) begin
          target = (64'(c.dice) * 64'(grid_sum)) >> 16;
          partial = 0;
          for (int i = 0; i < NSITES; i++) begin
            partial += 64'(jump_rate(grid_occ[i]));
            if (target < partial) begin
              src = i;
              found = 1'b1;
              break;
            end
          end
        end
        if (!found) begin
          res.status = 1'b1;
        end else begin
          dst = torus_neighbor(src, c.dir);
          so = grid_occ[src];
          dn = grid_occ[dst];
          acc = 64'(grid_sum) + 64'(jump_rate(so - 16'd1)) + 64'(jump_rate(dn + 16'd1))
                - 64'(jump_rate(so)) - 64'(jump_rate(dn));
          grid_sum = acc[39:0] & SUM_MASK;
          grid_occ[dst] = dn + 16'd1;
          grid_occ[src] = grid_occ[src] - 16'd1;
          if (grid_occ[dst] > grid_peak[dst]) begin
            grid_peak[dst] = grid_occ[dst];
            res.raised = 1'b1;
          end
          res.src = 10'(src);
          res.dst = 10'(dst);
          res.occ = grid_occ[dst];
          res.pk = grid_peak[dst];
        end
      end
      OP_READ: begin
        res.dst = c.site;
        res.occ = grid_occ[c.site];
        res.pk = grid_peak[c.site];
      end
      default: ;
    endcase
    expected_results.push_back(res);
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Driver: sender works in bursts with random gaps; a new command goes out only
  // once the previous one has transferred.
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (!rst && (!in_valid || n_accepted == n_driven)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        cur_cmd = pending_cmds.pop_front();
        opcode <= cur_cmd.op;
        dice <= cur_cmd.dice;
        direction <= cur_cmd.dir;
        read_site <= cur_cmd.site;
        in_valid <= 1'b1;
        n_driven <= n_driven + 1;
        if (burst_left <= 1) begin
          // Half the bursts run back to back with no gap at all.
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 9);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: picks among three stall patterns; one long hold-off lets the
  // block fill up and push back on its input.
  int rx_cycle = 0;
  int rx_mode = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 64 == 0) rx_mode <= $urandom_range(0, 2);
    if (!hold_done && n_accepted >= 60) begin
      hold_done <= 1'b1;
      hold_left <= 3000;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        default: out_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Monitor: predict on each input transfer, check each output transfer.
  result_t want;
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      predict_grid(cur_cmd);
      n_accepted <= n_accepted + 1;
    end
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 16'd1, 16'd0);
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status) report_mismatch("status", 16'(status), 16'(want.status));
        if (source_site !== want.src) report_mismatch("source_site", 16'(source_site),
                                                      16'(want.src));
        if (dest_site !== want.dst) report_mismatch("dest_site", 16'(dest_site), 16'(want.dst));
        if (occupancy !== want.occ) report_mismatch("occupancy", occupancy, want.occ);
        if (peak !== want.pk) report_mismatch("peak", peak, want.pk);
        if (new_peak !== want.raised) report_mismatch("new_peak", 16'(new_peak),
                                                      16'(want.raised));
      end
    end
  end

  task automatic add_cmd(input opcode_t op, input logic [15:0] d, input logic [1:0] dr,
                         input logic [9:0] s);
    cmd_t c;
    c.op = op;
    c.dice = d;
    c.dir = dr;
    c.site = s;
    pending_cmds.push_back(c);
  endtask

  // Mostly steps, with reads, occasional re-inits and no-ops mixed in.
  task automatic add_random(input int n);
    int pick;
    logic [15:0] d;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      d = ($urandom_range(0, 15) == 0) ? (($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0)
                                       : 16'($urandom);
      add_cmd(pick < 68 ? OP_STEP : pick < 90 ? OP_READ : pick < 95 ? OP_INIT : OP_NOP,
              d, 2'($urandom), 10'($urandom));
    end
  endtask

  // Hold the sender until every result is back, then let the block settle.
  task automatic drain();
    do @(posedge clk);
    while (pending_cmds.size() > 0 || n_accepted != n_driven || expected_results.size() > 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] a, input logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (a == ADDR_PARTICLE_COUNT) cfg_count = v[15:0];
    else cfg_bias = v[15:0];
  endtask

  task automatic set_config(input logic [15:0] cnt, input logic [15:0] bias);
    apb_write(ADDR_PARTICLE_COUNT, 32'(cnt));
    apb_write(ADDR_RATE_BIAS, 32'(bias));
  endtask

  initial begin
    for (int i = 0; i < NSITES; i++) begin
      grid_occ[i] = '0;
      grid_peak[i] = '0;
    end
    grid_sum = '0;
    cfg_count = 16'd0;
    cfg_bias = 16'd256;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Empty grid: steps refused on zero total rate, reads of never-filled sites.
    add_cmd(OP_STEP, 16'h8000, 2'd0, 10'd0);
    add_cmd(OP_READ, 16'h0, 2'd0, 10'd0);
    add_cmd(OP_READ, 16'hFFFF, 2'd3, 10'd1023);
    add_cmd(OP_NOP, 16'hFFFF, 2'd3, 10'h3FF);
    add_cmd(OP_INIT, 16'h0, 2'd0, 10'd0);
    add_cmd(OP_STEP, 16'hFFFF, 2'd3, 10'd0);
    drain();

    // Full particle count, largest bias: every direction, both dice extremes.
    set_config(16'hFFFF, 16'hFFFF);
    add_cmd(OP_INIT, 16'h0, 2'd0, 10'd0);
    add_cmd(OP_READ, 16'h0, 2'd0, 10'd0);
    add_cmd(OP_READ, 16'h0, 2'd0, 10'd1023);
    for (int dr = 0; dr < 4; dr++) add_cmd(OP_STEP, 16'h0, 2'(dr), 10'd0);
    add_cmd(OP_STEP, 16'hFFFF, 2'd1, 10'd0);
    add_cmd(OP_STEP, 16'hFFFF, 2'd3, 10'd0);
    add_random(100);
    drain();

    // Bias dropped after init: stale total leaves high dice with no site.
    set_config(16'hFFFF, 16'h0000);
    add_cmd(OP_STEP, 16'hFFFF, 2'd2, 10'd0);
    add_cmd(OP_STEP, 16'h0000, 2'd2, 10'd0);
    add_cmd(OP_READ, 16'h0, 2'd0, 10'd33);
    add_cmd(OP_INIT, 16'h0, 2'd0, 10'd0);
    add_cmd(OP_STEP, 16'hFFFF, 2'd0, 10'd0);
    add_random(40);
    drain();

    // Sparse grid: most sites empty, particles hop around and pile up.
    set_config(16'd5, 16'd256);
    add_cmd(OP_INIT, 16'h0, 2'd0, 10'd0);
    add_random(150);
    drain();

    set_config(16'd1500, 16'($urandom));
    add_cmd(OP_INIT, 16'h0, 2'd0, 10'd0);
    add_random(130);
    drain();

    set_config(16'($urandom), 16'($urandom));
    add_cmd(OP_INIT, 16'h0, 2'd0, 10'd0);
    add_random(100);
    drain();

    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(64'd4_000_000 * 20);
    $display("timeout");
    $display("Regression FAIL");
    $finish;
  end

endmodule
